>>> rtl/mlcf_pkg.sv
// ----------------------------------------------------------------------------
// mlcf_pkg : shared types and constants for the magic/length/CRC-8 deframer
// Phase and kind codes, register indexes, channel payloads and the CRC step.
// ----------------------------------------------------------------------------
package mlcf_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0] MAX_LEN_RESET = 16'd255;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;

	// parser phases
	localparam logic [2:0] PH_HUNT0 = 3'd0;
	localparam logic [2:0] PH_HUNT1 = 3'd1;
	localparam logic [2:0] PH_ID = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_LEN_HI = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_CRC = 3'd6;

	// result kinds
	localparam logic [2:0] KIND_HEADER = 3'd0;
	localparam logic [2:0] KIND_DATA = 3'd1;
	localparam logic [2:0] KIND_GOOD = 3'd2;
	localparam logic [2:0] KIND_BAD = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	typedef struct packed {
		logic [7:0] magic_first;
		logic [7:0] magic_second;
		logic [15:0] max_payload_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] message_id;
		logic [15:0] frame_length;
		logic [7:0] data_byte;
		logic [15:0] byte_offset;
		logic frame_last;
	} result_t;

	// one byte of CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] v;
		v = c ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
		end
		return v;
	endfunction

	// phase transition of the sync hunt, used when a rejected header is re-parsed
	function automatic logic [2:0] hunt_step(input logic [2:0] ph, input logic [7:0] b,
			input logic [7:0] mf, input logic [7:0] ms);
		logic [2:0] nxt;
		case (ph)
			PH_HUNT1: begin
				if (b == ms) nxt = PH_ID;
				else if (b == mf) nxt = PH_HUNT1;
				else nxt = PH_HUNT0;
			end
			PH_ID: nxt = PH_LEN_LO;
			default: nxt = (b == mf) ? PH_HUNT1 : PH_HUNT0;
		endcase
		return nxt;
	endfunction

endpackage

>>> rtl/mlcf_stream_if.sv
// ----------------------------------------------------------------------------
// mlcf_stream_if : valid/ready channels of the deframer
// Byte channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface mlcf_byte_if;
	logic valid;
	logic ready;
	mlcf_pkg::rx_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mlcf_result_if;
	logic valid;
	logic ready;
	mlcf_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/mlcf_parser.sv
// ----------------------------------------------------------------------------
// mlcf_parser : frame parse state and per-byte next-state logic
// Holds phase, header fields, payload count and running CRC; advances on step.
// ----------------------------------------------------------------------------
module mlcf_parser (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] byte_in,
	input mlcf_pkg::cfg_t cfg,
	output logic has_result,
	output mlcf_pkg::result_t result
);

	logic [2:0] phase_q, phase_d;
	logic [7:0] id_q, id_d;
	logic [7:0] len_lo_q, len_lo_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0] crc_q, crc_d;

	logic [7:0] crc_b;
	logic [7:0] crc_magic;
	logic [15:0] len_new;
	logic [2:0] rp1, rp2, rp3;

	assign crc_b = mlcf_pkg::crc8_update(crc_q, byte_in);
	assign crc_magic = mlcf_pkg::crc8_update(
		mlcf_pkg::crc8_update(mlcf_pkg::CRC_INIT, cfg.magic_first), cfg.magic_second);
	assign len_new = {byte_in, len_lo_q};

	// re-parse of id, length low and length high after a rejected length
	assign rp1 = mlcf_pkg::hunt_step(mlcf_pkg::PH_HUNT0, id_q,
		cfg.magic_first, cfg.magic_second);
	assign rp2 = mlcf_pkg::hunt_step(rp1, len_lo_q, cfg.magic_first, cfg.magic_second);
	assign rp3 = mlcf_pkg::hunt_step(rp2, byte_in, cfg.magic_first, cfg.magic_second);

	always_comb begin
		phase_d = phase_q;
		id_d = id_q;
		len_lo_d = len_lo_q;
		len_d = len_q;
		count_d = count_q;
		crc_d = crc_q;
		has_result = 1'b0;
		result.kind = mlcf_pkg::KIND_HEADER;
		result.message_id = id_q;
		result.frame_length = len_q;
		result.data_byte = 8'h00;
		result.byte_offset = 16'h0000;
		result.frame_last = 1'b0;
		unique case (phase_q)
			mlcf_pkg::PH_HUNT1: begin
				if (byte_in == cfg.magic_second) begin
					crc_d = crc_magic;
					phase_d = mlcf_pkg::PH_ID;
				end else if (byte_in != cfg.magic_first) begin
					phase_d = mlcf_pkg::PH_HUNT0;
				end
			end
			mlcf_pkg::PH_ID: begin
				id_d = byte_in;
				crc_d = crc_b;
				phase_d = mlcf_pkg::PH_LEN_LO;
			end
			mlcf_pkg::PH_LEN_LO: begin
				len_lo_d = byte_in;
				crc_d = crc_b;
				phase_d = mlcf_pkg::PH_LEN_HI;
			end
			mlcf_pkg::PH_LEN_HI: begin
				len_d = len_new;
				count_d = 16'h0000;
				has_result = 1'b1;
				result.frame_length = len_new;
				if (len_new > cfg.max_payload_len) begin
					result.kind = mlcf_pkg::KIND_REJECT;
					result.frame_last = 1'b1;
					phase_d = rp3;
					if (rp3 == mlcf_pkg::PH_ID) begin
						crc_d = crc_magic;
					end else if (rp3 == mlcf_pkg::PH_LEN_LO) begin
						// magic pair found in the replay, high byte taken as the id
						crc_d = mlcf_pkg::crc8_update(crc_magic, byte_in);
						id_d = byte_in;
					end else begin
						crc_d = crc_b;
					end
				end else begin
					phase_d = (len_new == 16'h0000) ? mlcf_pkg::PH_CRC : mlcf_pkg::PH_PAYLOAD;
					crc_d = crc_b;
				end
			end
			mlcf_pkg::PH_PAYLOAD: begin
				crc_d = crc_b;
				has_result = 1'b1;
				result.kind = mlcf_pkg::KIND_DATA;
				result.data_byte = byte_in;
				result.byte_offset = count_q;
				count_d = count_q + 16'd1;
				if (count_d >= len_q) phase_d = mlcf_pkg::PH_CRC;
			end
			mlcf_pkg::PH_CRC: begin
				has_result = 1'b1;
				result.kind = (byte_in == crc_q) ? mlcf_pkg::KIND_GOOD : mlcf_pkg::KIND_BAD;
				result.frame_last = 1'b1;
				phase_d = mlcf_pkg::PH_HUNT0;
			end
			default: begin
				phase_d = (byte_in == cfg.magic_first) ? mlcf_pkg::PH_HUNT1 : mlcf_pkg::PH_HUNT0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mlcf_pkg::PH_HUNT0;
			id_q <= 8'h00;
			len_lo_q <= 8'h00;
			len_q <= 16'h0000;
			count_q <= 16'h0000;
			crc_q <= mlcf_pkg::CRC_INIT;
		end else if (step) begin
			phase_q <= phase_d;
			id_q <= id_d;
			len_lo_q <= len_lo_d;
			len_q <= len_d;
			count_q <= count_d;
			crc_q <= crc_d;
		end
	end

endmodule

>>> rtl/magic_length_crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// magic_length_crc8_frame_receiver : magic-synchronised CRC-8 frame deframer
// Hunts for the magic pair, parses id and length, streams payload and checks
// the trailing CRC-8 (poly 0x07, init 0).
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  ------------------------------------------
//  rx       in   valid / ready    rx_byte
//  res      out  valid / ready    kind, message_id, frame_length, data_byte,
//                                 byte_offset, frame_last
//  cfg      in   cfg_we           cfg_index, cfg_wdata (no read-back)
//
//  One byte per cycle sustained while res is not stalled. A byte is taken into
//  the input register on its rx transaction; the parser works on the input
//  register combinationally and its result loads into the result register,
//  which drives res valid. The CRC update and phase change are one byte-wide
//  step in the parser. Reset is asynchronous, active low, and leaves the block
//  hunting for the first magic byte with max_payload_len at 255. When res
//  stalls, the result register holds and one further byte waits in the input
//  register; bytes that produce no result still drain past a stalled output.
//
module magic_length_crc8_frame_receiver (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mlcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mlcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	mlcf_byte_if.sink rx,
	mlcf_result_if.source res
);

	// configuration registers
	mlcf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_first <= 8'h00;
			cfg_q.magic_second <= 8'h00;
			cfg_q.max_payload_len <= mlcf_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mlcf_pkg::REG_MAGIC_FIRST: cfg_q.magic_first <= cfg_wdata[7:0];
				mlcf_pkg::REG_MAGIC_SECOND: cfg_q.magic_second <= cfg_wdata[7:0];
				mlcf_pkg::REG_MAX_LEN: cfg_q.max_payload_len <= cfg_wdata[15:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// input stage
	logic valid_s1;
	logic [7:0] byte_s1;
	logic advance;
	logic has_result;
	mlcf_pkg::result_t result;

	// a byte leaves the input stage unless it carries a result that cannot
	// be placed in the result register this cycle
	assign advance = valid_s1 && (!has_result || !res.valid || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) byte_s1 <= rx.payload.rx_byte;
	end

	mlcf_parser u_parser (
		.clk (clk),
		.arst_n (arst_n),
		.step (advance),
		.byte_in (byte_s1),
		.cfg (cfg_q),
		.has_result (has_result),
		.result (result)
	);

	// result register
	logic res_valid_s2;
	mlcf_pkg::result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && has_result) begin
			res_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) res_s2 <= result;
	end

	assign res.valid = res_valid_s2;
	assign res.payload = res_s2;

	// checks
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.payload.frame_last == (res.payload.kind == mlcf_pkg::KIND_GOOD
			|| res.payload.kind == mlcf_pkg::KIND_BAD
			|| res.payload.kind == mlcf_pkg::KIND_REJECT)))
		else $error("frame_last disagrees with kind");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.payload.kind == mlcf_pkg::KIND_DATA
			|-> res.payload.byte_offset < res.payload.frame_length)
		else $error("payload offset beyond frame length");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.payload.kind != mlcf_pkg::KIND_DATA
			|-> res.payload.data_byte == 8'h00 && res.payload.byte_offset == 16'h0000)
		else $error("non-payload result carries data");

	a_no_lost_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && has_result && res.valid && !res.ready)
		else $error("input stalled without a blocked result");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result |=> res.valid)
		else $error("result not presented after load");

endmodule
